/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL. They reduce to nothing when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/pns_pkg.sv */
// ---------------------------------------------------------------------------
// pns_pkg
// Shared constants, codes and control structs of the path normaliser.
// ---------------------------------------------------------------------------
package pns_pkg;

  // Sizing
  localparam int RING_DEPTH = 16;
  localparam int MAX_LEN    = 4096;
  localparam int CNT_W      = $clog2(RING_DEPTH);
  localparam int POS_W      = $clog2(MAX_LEN);
  localparam int LEN_W      = $clog2(MAX_LEN + 1);

  // Characters of interest
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_DROP   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_REWIND = 2'd2
  } action_t;

  // Shift mode of the split-point chain
  typedef enum logic [1:0] {
    RING_HOLD = 2'd0,
    RING_PUSH = 2'd1,
    RING_POP  = 2'd2
  } ring_op_t;

  // Control from the decision logic to the chain
  typedef struct packed {
    ring_op_t         op;
    logic [POS_W-1:0] data;
    logic             clear;
  } ring_ctrl_t;

  // Status from the chain to the decision logic
  typedef struct packed {
    logic [POS_W-1:0] below_top;
    logic [CNT_W-1:0] count;
  } ring_stat_t;

endpackage

/* sv/pns_cell.sv */
// ---------------------------------------------------------------------------
// pns_cell
// One slot of the split-point chain. Takes the value of its upper neighbour
// on a push, of its lower neighbour on a pop, and holds otherwise.
// ---------------------------------------------------------------------------
module pns_cell (
  input  logic                    clk,
  input  pns_pkg::ring_op_t       op,
  input  logic [pns_pkg::POS_W-1:0] from_prev,
  input  logic [pns_pkg::POS_W-1:0] from_next,
  output logic [pns_pkg::POS_W-1:0] value
);
  import pns_pkg::*;

  // Slot contents are undefined until written, so no reset
  always_ff @(posedge clk) begin
    unique case (op)
      RING_PUSH: value <= from_prev;
      RING_POP:  value <= from_next;
      default:   value <= value;
    endcase
  end

endmodule

/* sv/pns_ring.sv */
// ---------------------------------------------------------------------------
// pns_ring
// Folder split-point ring built as a rotating chain of cells. Cell k holds
// the entry k places below the ring head, so a push or pop is one shift.
// The fill count stands in for the head/tail pointer pair.
// ---------------------------------------------------------------------------
module pns_ring (
  input  logic                clk,
  input  logic                rst,
  input  pns_pkg::ring_ctrl_t ctrl,
  output pns_pkg::ring_stat_t stat
);
  import pns_pkg::*;

  logic [POS_W-1:0] cell_q [RING_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Row of cells, closed into a loop; the head cell takes fresh data on push
  for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
    logic [POS_W-1:0] prev_val;
    if (k == 0) begin : g_head
      assign prev_val = ctrl.data;
    end else begin : g_body
      assign prev_val = cell_q[k-1];
    end
    pns_cell u_cell (
      .clk       (clk),
      .op        (ctrl.op),
      .from_prev (prev_val),
      .from_next (cell_q[(k + 1) % RING_DEPTH]),
      .value     (cell_q[k])
    );
  end

  // Fill count: saturates on push, wraps below zero on pop
  always_comb begin
    count_next = count;
    unique case (ctrl.op)
      RING_PUSH: begin
        if (count != CNT_W'(RING_DEPTH - 1)) count_next = count + CNT_W'(1);
      end
      RING_POP: begin
        if (count == '0) count_next = CNT_W'(RING_DEPTH - 1);
        else             count_next = count - CNT_W'(1);
      end
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // A pop reads the entry just below the head
  assign stat.below_top = cell_q[1];
  assign stat.count     = count;

endmodule

/* sv/path_normalizer_stream_top.sv */
// A result is registered and presented in the cycle after its input transaction.
// Throughput: one byte per cycle while the output register is not stalled; the
// write position and split-point chain update in the accept cycle, so consecutive bytes follow back to back.
// Reset (rst, synchronous) clears the write position, the ring fill count,
// the slash and skip flags and the output valid; a byte marked last clears all
// but the output valid on acceptance. Split-point cells are not cleared.
// ---------------------------------------------------------------------------
// path_normalizer_stream_top
// Streaming file path normaliser, one path byte per transaction, with two
// bytes of lookahead and a registered output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module path_normalizer_stream_top (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  cur_char,
  input  logic [7:0]                  next_char,
  input  logic                        next_valid,
  input  logic [7:0]                  after_char,
  input  logic                        after_valid,
  input  logic                        last_char,
  // Output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output pns_pkg::action_t            action,
  output logic [pns_pkg::POS_W-1:0]   position,
  output logic [7:0]                  out_char,
  output logic [pns_pkg::LEN_W-1:0]   length,
  output logic                        overflow,
  output logic                        last
);
  import pns_pkg::*;

  logic             accept;
  logic [LEN_W-1:0] write_pos;
  logic [LEN_W-1:0] write_pos_next;
  logic             prev_was_slash;
  logic             prev_was_slash_next;
  logic             skip_next;
  logic             skip_next_next;

  logic [7:0]       cur_conv;
  logic             slash;
  logic             sep_nxt;
  logic             sep_aft;
  logic             take_write;
  ring_op_t         op_sel;
  action_t          act_sel;
  logic [POS_W-1:0] pos_sel;
  logic [7:0]       ch_sel;
  logic             ovf_sel;

  ring_ctrl_t       rctrl;
  ring_stat_t       rstat;

  // Output register frees the input side whenever it is empty or draining
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Character classification
  assign cur_conv = (cur_char == CH_BSLASH) ? CH_SLASH : cur_char;
  assign slash    = (cur_conv == CH_SLASH);
  assign sep_nxt  = (next_char == CH_SLASH) || (next_char == CH_BSLASH);
  assign sep_aft  = (after_char == CH_SLASH) || (after_char == CH_BSLASH);

  // Per-byte decision
  always_comb begin
    write_pos_next      = write_pos;
    prev_was_slash_next = prev_was_slash;
    skip_next_next      = skip_next;
    take_write          = 1'b0;
    op_sel              = RING_HOLD;
    act_sel             = ACT_DROP;
    pos_sel             = '0;
    ch_sel              = '0;
    ovf_sel             = 1'b0;

    if (skip_next) begin
      // second dot of a parent segment
      skip_next_next = 1'b0;
    end else begin
      take_write = 1'b1;
      priority if (prev_was_slash && slash) begin
        take_write = 1'b0;
      end else if (prev_was_slash && cur_conv == CH_DOT && (!next_valid || sep_nxt)) begin
        take_write = 1'b0;
      end else if (prev_was_slash && cur_conv == CH_DOT && next_char == CH_DOT &&
                   (!after_valid || sep_aft)) begin
        // parent segment: pop always, rewind unless the fill count is one
        op_sel = RING_POP;
        if (rstat.count != CNT_W'(1)) begin
          take_write     = 1'b0;
          write_pos_next = {1'b0, rstat.below_top} + LEN_W'(1);
          skip_next_next = 1'b1;
          act_sel        = ACT_REWIND;
        end
      end else begin
        take_write = 1'b1;
      end

      if (take_write) begin
        if (write_pos >= LEN_W'(MAX_LEN)) begin
          ovf_sel = 1'b1;
        end else begin
          if (slash) op_sel = RING_PUSH;
          act_sel        = ACT_WRITE;
          pos_sel        = write_pos[POS_W-1:0];
          ch_sel         = (cur_conv >= CH_UPPER_A && cur_conv <= CH_UPPER_Z) ?
                           cur_conv + CASE_OFFSET : cur_conv;
          write_pos_next = write_pos + LEN_W'(1);
        end
        prev_was_slash_next = slash;
      end
    end
  end

  // Split-point chain
  assign rctrl.op    = accept ? op_sel : RING_HOLD;
  assign rctrl.data  = write_pos[POS_W-1:0];
  assign rctrl.clear = accept && last_char;

  pns_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rctrl),
    .stat (rstat)
  );

  // Path state, cleared after the final byte of a path
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos      <= '0;
      prev_was_slash <= 1'b0;
      skip_next      <= 1'b0;
    end else if (accept) begin
      if (last_char) begin
        write_pos      <= '0;
        prev_was_slash <= 1'b0;
        skip_next      <= 1'b0;
      end else begin
        write_pos      <= write_pos_next;
        prev_was_slash <= prev_was_slash_next;
        skip_next      <= skip_next_next;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      action   <= act_sel;
      position <= pos_sel;
      out_char <= ch_sel;
      length   <= write_pos_next;
      overflow <= ovf_sel;
      last     <= last_char;
    end
  end

  // Checks
  `ASSERT_NEXT(a_skip_drops, clk, rst, accept && skip_next, out_valid && action == ACT_DROP)
  `ASSERT_NEXT(a_rewind_arms_skip, clk, rst, accept && act_sel == ACT_REWIND && !last_char, skip_next)
  `ASSERT_IMPLY(a_write_length, clk, rst, out_valid && action == ACT_WRITE, length == {1'b0, position} + LEN_W'(1))
  `ASSERT_IMPLY(a_rewind_nonzero, clk, rst, out_valid && action == ACT_REWIND, length != '0)

endmodule

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming path normaliser. Paths are fed one
// byte per transaction with two bytes of lookahead. A local predictor keeps
// its own split-point ring, write position and slash/skip flags, and every
// result is compared field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
  import pns_pkg::*;

  localparam int IDLE_LIMIT   = 200;
  localparam int RANDOM_BYTES = 700;
  localparam logic [7:0] CH_FILLER = 8'h78;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    action_t          act;
    logic [POS_W-1:0] pos;
    logic [7:0]       ch;
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             lst;
  } norm_result_t;

  // DUT connections
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       cur_char = '0;
  logic [7:0]       next_char = '0;
  logic             next_valid = 1'b0;
  logic [7:0]       after_char = '0;
  logic             after_valid = 1'b0;
  logic             last_char = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  action_t          action;
  logic [POS_W-1:0] position;
  logic [7:0]       out_char;
  logic [LEN_W-1:0] length;
  logic             overflow;
  logic             last;

  // Predictor state
  logic [POS_W-1:0]      split_pts [RING_DEPTH];
  logic [RING_DEPTH-1:0] split_set;
  logic [CNT_W-1:0]      head_ix;
  logic [CNT_W-1:0]      tail_ix;
  logic [LEN_W-1:0]      wr_pos;
  logic                  after_slash;
  logic                  drop_next;

  norm_result_t pending[$];
  norm_result_t oldest;
  int           stall_left = 0;
  int           idle_cycles = 0;
  bit           idle_on = 1'b1;
  int           n_errors = 0;
  int           n_bytes = 0;
  int           n_paths = 0;
  int           n_rewinds = 0;
  int           n_checked = 0;

  path_normalizer_stream_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cur_char(cur_char), .next_char(next_char), .next_valid(next_valid),
    .after_char(after_char), .after_valid(after_valid), .last_char(last_char),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .position(position), .out_char(out_char),
    .length(length), .overflow(overflow), .last(last)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic is_sep(logic [7:0] c);
    return c == CH_SLASH || c == CH_BSLASH;
  endfunction

  function automatic void clear_norm_state();
    head_ix     = '0;
    tail_ix     = '0;
    wr_pos      = '0;
    after_slash = 1'b0;
    drop_next   = 1'b0;
    split_set   = '0;
  endfunction

  // True when this byte would rewind to a split cell never filled this path
  function automatic logic pops_blank(logic [7:0] c, logic [7:0] n, logic nv,
                                      logic [7:0] a, logic av);
    logic [CNT_W-1:0] below;
    below = head_ix - 1'b1;
    return !drop_next && after_slash && c == CH_DOT && nv && !is_sep(n) &&
           n == CH_DOT && (!(av && nv) || is_sep(a)) && below != tail_ix &&
           !split_set[below];
  endfunction

  function automatic norm_result_t normalise_byte(logic [7:0] c, logic [7:0] n,
                                                  logic nv, logic [7:0] a,
                                                  logic av, logic lst);
    norm_result_t r;
    logic [7:0]   ch;
    logic         slash;
    logic         handled;
    r.act = ACT_DROP;
    r.pos = '0;
    r.ch  = '0;
    r.ovf = 1'b0;
    r.lst = lst;
    if (drop_next) begin
      // second dot of a rewound ".." segment
      drop_next = 1'b0;
    end else begin
      ch      = (c == CH_BSLASH) ? CH_SLASH : c;
      slash   = (ch == CH_SLASH);
      handled = 1'b0;
      if (after_slash) begin
        if (slash) begin
          handled = 1'b1;
        end else if (ch == CH_DOT) begin
          if (!nv || is_sep(n)) begin
            handled = 1'b1;
          end else if (n == CH_DOT && (!(av && nv) || is_sep(a))) begin
            // pop; an empty ring leaves the head stepped back
            head_ix = head_ix - 1'b1;
            if (head_ix != tail_ix) begin
              wr_pos    = {1'b0, split_pts[head_ix]} + 1'b1;
              drop_next = 1'b1;
              r.act     = ACT_REWIND;
              handled   = 1'b1;
              n_rewinds++;
            end
          end
        end
      end
      if (!handled) begin
        if (wr_pos >= MAX_LEN) begin
          r.ovf = 1'b1;
        end else begin
          if (slash) begin
            head_ix = head_ix + 1'b1;
            if (head_ix == tail_ix) tail_ix = head_ix + 1'b1;
            split_pts[head_ix] = wr_pos[POS_W-1:0];
            split_set[head_ix] = 1'b1;
          end
          r.act  = ACT_WRITE;
          r.pos  = wr_pos[POS_W-1:0];
          r.ch   = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + CASE_OFFSET : ch;
          wr_pos = wr_pos + 1'b1;
        end
        after_slash = slash;
      end
    end
    r.len = wr_pos;
    if (lst) clear_norm_state();
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [7:0] c, input logic [7:0] n, input logic nv,
                           input logic [7:0] a, input logic av, input logic lst);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (pops_blank(c, n, nv, a, av)) c = CH_FILLER;
    in_valid    <= 1'b1;
    cur_char    <= c;
    next_char   <= n;
    next_valid  <= nv;
    after_char  <= a;
    after_valid <= av;
    last_char   <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(normalise_byte(c, n, nv, a, av, lst));
    n_bytes++;
  endtask

  // Feed a whole path with consistent lookahead, last byte marked
  task automatic feed_path(input byte_q_t p);
    int n;
    n = p.size();
    for (int i = 0; i < n; i++)
      send_item(p[i], (i + 1 < n) ? p[i + 1] : 8'($urandom), i + 1 < n,
                (i + 2 < n) ? p[i + 2] : 8'($urandom), i + 2 < n, i == n - 1);
    n_paths++;
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] pick_sep();
    return ($urandom_range(0, 2) == 0) ? CH_BSLASH : CH_SLASH;
  endfunction

  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 6))
      0, 1: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
      2, 3: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)) + CASE_OFFSET;
      4: return ($urandom_range(0, 1) != 0) ? CH_UPPER_A - 8'd1 : CH_UPPER_Z + 8'd1;
      5: return CH_DOT;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_noise_char();
    case ($urandom_range(0, 4))
      0: return CH_SLASH;
      1: return CH_BSLASH;
      2: return CH_DOT;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random path of nseg segments: names, ".", ".." and "..."
  function automatic byte_q_t make_path(int nseg);
    byte_q_t p;
    if ($urandom_range(0, 3) != 0) p.push_back(pick_sep());
    for (int s = 0; s < nseg; s++) begin
      case ($urandom_range(0, 9))
        0, 1: p.push_back(CH_DOT);
        2, 3, 4: begin
          p.push_back(CH_DOT);
          p.push_back(CH_DOT);
        end
        5: repeat (3) p.push_back(CH_DOT);
        default: repeat ($urandom_range(1, 4)) p.push_back(pick_name_char());
      endcase
      if (s < nseg - 1 || $urandom_range(0, 1) != 0) begin
        p.push_back(pick_sep());
        if ($urandom_range(0, 4) == 0) p.push_back(pick_sep());
      end
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed_cases();
    // backslash, capitals, repeated slash, lone dot, two rewinds
    feed_path(to_bytes("\\Ab//./Z/../.."));
    // ".." with an empty ring writes the dots
    feed_path(to_bytes("/../x"));
    // lone dot at the end of the path
    feed_path(to_bytes("/."));
    // after_valid without next_valid, and byte extremes
    send_item(CH_SLASH, CH_DOT, 1'b1, CH_DOT, 1'b1, 1'b0);
    send_item(CH_DOT, CH_DOT, 1'b0, CH_SLASH, 1'b1, 1'b0);
    send_item(8'h00, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1);
    drain_results();
  endtask

  task automatic test_random_paths();
    int  start;
    bit  paused;
    start  = n_bytes;
    paused = 1'b0;
    while (n_bytes - start < RANDOM_BYTES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        // noise: unrelated lookahead, random valids and last
        repeat ($urandom_range(1, 4))
          send_item(pick_noise_char(), pick_noise_char(), 1'($urandom),
                    pick_noise_char(), 1'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        feed_path(make_path(($urandom_range(0, 4) == 0) ? $urandom_range(16, 30)
                                                         : $urandom_range(1, 6)));
      end
      if (!paused && n_bytes - start >= RANDOM_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    idle_on = 1'b1;
    drain_results();
  endtask

  // ---------------------------------------------------------------------
  // Result checker and output stall
  // ---------------------------------------------------------------------
  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $display("%0t: result transaction with nothing outstanding", $time);
          n_errors++;
        end else begin
          oldest = pending.pop_front();
          check_field("action", 16'(oldest.act), 16'(action));
          check_field("position", 16'(oldest.pos), 16'(position));
          check_field("out_char", 16'(oldest.ch), 16'(out_char));
          check_field("length", 16'(oldest.len), 16'(length));
          check_field("overflow", 16'(oldest.ovf), 16'(overflow));
          check_field("last", 16'(oldest.lst), 16'(last));
          n_checked++;
        end
        stall_left = idle_on ? $urandom_range(0, 3) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    clear_norm_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_paths();
    repeat (8) @(posedge clk);
    $display("Covered %0d bytes in %0d paths, %0d results checked,",
             n_bytes, n_paths, n_checked);
    $display("including %0d rewinds through the split-point ring.", n_rewinds);
    if (n_errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/pns_pkg.sv
sv/pns_cell.sv
sv/pns_ring.sv
sv/path_normalizer_stream_top.sv
tb/sv/tb.sv
